// File: rtl/qus_pkg.sv
// Types, constants and helper functions shared by the quadtree split block.
// No dependencies; used by qus_ctrl, qus_datapath and the top level of the block.
package qus_pkg;

   localparam int GridLog = 3;
   localparam int Grid    = 1 << GridLog;
   localparam int CellW   = 2 * GridLog;
   localparam int NumCell = Grid * Grid;
   localparam int PixW    = 8;
   localparam int CoordW  = 8;
   localparam int DimW    = 9;
   localparam int DepthW  = 2;
   localparam int PathW   = 2 * GridLog;
   localparam int RspW    = 48;

   localparam logic [DimW-1:0] MIN_DIM = 9'd8;
   localparam logic [DimW-1:0] MAX_DIM = 9'd256;

   // register indexes on the csr port
   localparam logic [1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_THRESHOLD    = 2'd2;
   localparam logic [1:0] CSR_DEPTH_LIMIT  = 2'd3;

   // quadrant codes in walk order
   localparam logic [1:0] Q_TL = 2'd0;
   localparam logic [1:0] Q_TR = 2'd1;
   localparam logic [1:0] Q_BR = 2'd2;
   localparam logic [1:0] Q_BL = 2'd3;

   typedef struct packed {
      logic [CoordW-1:0]  xb;
      logic [CoordW-1:0]  xe;
      logic [CoordW-1:0]  yb;
      logic [CoordW-1:0]  ye;
      logic [GridLog-1:0] cx;
      logic [GridLog-1:0] cy;
   } region_type;

   typedef struct packed {
      logic intake_en;
      logic walk_start;
      logic scan_step;
      logic descend;
      logic advance;
      logic emit;
      logic clear;
   } cmd_type;

   typedef struct packed {
      logic last_accept;
      logic scan_last;
      logic split;
      logic last_leaf;
      logic out_free;
   } status_type;

   function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] v);
      logic [DimW-1:0] r;
      if (v < MIN_DIM) r = MIN_DIM;
      else if (v > MAX_DIM) r = MAX_DIM;
      else r = v;
      return r;
   endfunction

   function automatic logic [CoordW-1:0] mid(input logic [CoordW-1:0] b,
                                             input logic [CoordW-1:0] e);
      logic [CoordW:0] s;
      s = {1'b0, b} + {1'b0, e};
      return s[CoordW:1];
   endfunction

   // finest cell of a coordinate along one axis, nested midpoint splits
   function automatic logic [GridLog-1:0] axis_cell(input logic [CoordW-1:0] p,
                                                    input logic [CoordW-1:0] last);
      logic [CoordW-1:0]  b;
      logic [CoordW-1:0]  e;
      logic [CoordW-1:0]  m;
      logic [GridLog-1:0] c;
      b = '0;
      e = last;
      c = '0;
      for (int i = 0; i < GridLog; i++) begin
         m = mid(b, e);
         if (p <= m) begin
            c = {c[GridLog-2:0], 1'b0};
            e = m;
         end else begin
            c = {c[GridLog-2:0], 1'b1};
            b = m + 8'd1;
         end
      end
      return c;
   endfunction

   // quadrant q of a parent region; cdepth is the child's depth (1 or more)
   function automatic region_type child(input region_type par, input logic [1:0] q,
                                        input logic [DepthW-1:0] cdepth);
      region_type         r;
      logic [GridLog:0]   sp;
      logic [GridLog-1:0] h;
      logic [CoordW-1:0]  mx;
      logic [CoordW-1:0]  my;
      logic               hx;
      logic               hy;
      sp = (GridLog+1)'(Grid) >> cdepth;
      h  = sp[GridLog-1:0];
      mx = mid(par.xb, par.xe);
      my = mid(par.yb, par.ye);
      hx = (q == Q_TR) || (q == Q_BR);
      hy = (q == Q_BR) || (q == Q_BL);
      r.xb = hx ? mx + 8'd1 : par.xb;
      r.xe = hx ? par.xe : mx;
      r.yb = hy ? my + 8'd1 : par.yb;
      r.ye = hy ? par.ye : my;
      r.cx = hx ? par.cx + h : par.cx;
      r.cy = hy ? par.cy + h : par.cy;
      return r;
   endfunction

endpackage

// File: rtl/qus_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module qus_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/qus_ctrl.sv
// Controller of the quadtree split block: intake, drain, scan, wait, decide and emit sequencing.
// Depends on qus_pkg.
module qus_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  qus_pkg::status_type sts,
   output qus_pkg::cmd_type    cmd
);

   localparam logic [2:0] ST_INTAKE = 3'd0;
   localparam logic [2:0] ST_DRAIN  = 3'd1;
   localparam logic [2:0] ST_SCAN   = 3'd2;
   localparam logic [2:0] ST_WAIT   = 3'd3;
   localparam logic [2:0] ST_DECIDE = 3'd4;
   localparam logic [2:0] ST_EMIT   = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_INTAKE: begin
            cmd.intake_en = 1'b1;
            if (sts.last_accept) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            cmd.walk_start = 1'b1;
            state_in       = ST_SCAN;
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_last) state_in = ST_WAIT;
         end
         ST_WAIT: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (sts.split) begin
               cmd.descend = 1'b1;
               state_in    = ST_SCAN;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               if (sts.last_leaf) begin
                  cmd.clear = 1'b1;
                  state_in  = ST_INTAKE;
               end else begin
                  cmd.advance = 1'b1;
                  state_in    = ST_SCAN;
               end
            end
         end
         default: state_in = ST_INTAKE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_INTAKE;
      else state_ff <= state_in;
   end

endmodule

// File: rtl/qus_datapath.sv
// Datapath: config registers, pixel counters, cell min/max store, region walk, result register.
// Depends on qus_pkg and qus_ram.
module qus_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  qus_pkg::cmd_type     cmd,
   output qus_pkg::status_type  sts,
   input  logic                 csr_we,
   input  logic [1:0]           csr_index,
   input  logic [8:0]           csr_wdata,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [7:0]           req_tdata,
   input  logic                 req_tlast,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [47:0]          rsp_tdata,
   output logic                 rsp_tlast
);

   localparam int CellW  = qus_pkg::CellW;
   localparam int GL     = qus_pkg::GridLog;

   // configuration
   logic [8:0] width_ff, height_ff;
   logic [7:0] thr_ff;
   logic [1:0] dlim_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 9'd256;
         height_ff <= 9'd256;
         thr_ff    <= 8'd5;
         dlim_ff   <= 2'd3;
      end else if (csr_we) begin
         case (csr_index)
            qus_pkg::CSR_IMAGE_WIDTH:  width_ff  <= csr_wdata;
            qus_pkg::CSR_IMAGE_HEIGHT: height_ff <= csr_wdata;
            qus_pkg::CSR_THRESHOLD:    thr_ff    <= csr_wdata[7:0];
            qus_pkg::CSR_DEPTH_LIMIT:  dlim_ff   <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   logic [8:0] wc, hc, wl9, hl9;
   assign wc  = qus_pkg::clamp_dim(width_ff);
   assign hc  = qus_pkg::clamp_dim(height_ff);
   assign wl9 = wc - 9'd1;
   assign hl9 = hc - 9'd1;

   // pixel intake
   logic             accept;
   logic [8:0]       col_ff, row_ff, col_inc;
   logic             in_range;
   logic [CellW-1:0] pix_cell;

   assign req_tready      = cmd.intake_en;
   assign accept          = req_tvalid & cmd.intake_en;
   assign sts.last_accept = accept & req_tlast;
   assign in_range        = (col_ff < wc) && (row_ff < hc);
   assign pix_cell        = {qus_pkg::axis_cell(row_ff[7:0], hl9[7:0]),
                             qus_pkg::axis_cell(col_ff[7:0], wl9[7:0])};
   assign col_inc         = col_ff + 9'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         if (req_tlast) begin
            col_ff <= '0;
            row_ff <= '0;
         end else if (col_inc >= wc) begin
            col_ff <= '0;
            if (row_ff < hc) row_ff <= row_ff + 9'd1;
         end else begin
            col_ff <= col_inc;
         end
      end
   end

   // read-modify-write stage with forwarding of the previous write
   localparam int NumCellW = qus_pkg::NumCell;
   logic             s1_vld_ff;
   logic [CellW-1:0] s1_addr_ff;
   logic [7:0]       s1_pix_ff;
   logic             lw_vld_ff;
   logic [CellW-1:0] lw_addr_ff;
   logic [15:0]      lw_data_ff;
   logic [15:0]      rd_data;
   logic             rd_vld_ff;
   logic [NumCellW-1:0] cvld_ff;
   logic [CellW-1:0] raddr, walk_addr;
   logic [7:0]       base_lo, base_hi, new_lo, new_hi;
   logic [15:0]      wdata;

   always_comb begin
      if (lw_vld_ff && (lw_addr_ff == s1_addr_ff)) begin
         base_lo = lw_data_ff[15:8];
         base_hi = lw_data_ff[7:0];
      end else if (rd_vld_ff) begin
         base_lo = rd_data[15:8];
         base_hi = rd_data[7:0];
      end else begin
         base_lo = 8'hFF;
         base_hi = 8'h00;
      end
      new_lo = (s1_pix_ff < base_lo) ? s1_pix_ff : base_lo;
      new_hi = (s1_pix_ff > base_hi) ? s1_pix_ff : base_hi;
      wdata  = {new_lo, new_hi};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         lw_vld_ff <= 1'b0;
         cvld_ff   <= '0;
      end else begin
         s1_vld_ff <= accept & in_range;
         if (cmd.clear) begin
            lw_vld_ff <= 1'b0;
            cvld_ff   <= '0;
         end else if (s1_vld_ff) begin
            lw_vld_ff            <= 1'b1;
            cvld_ff[s1_addr_ff]  <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      s1_addr_ff <= pix_cell;
      s1_pix_ff  <= req_tdata;
      rd_vld_ff  <= cvld_ff[raddr];
      if (s1_vld_ff) begin
         lw_addr_ff <= s1_addr_ff;
         lw_data_ff <= wdata;
      end
   end

   assign raddr = cmd.intake_en ? pix_cell : walk_addr;

   qus_ram #(.WIDTH(16), .DEPTH(qus_pkg::NumCell)) u_cells (
      .clock (clock),
      .we    (s1_vld_ff),
      .waddr (s1_addr_ff),
      .wdata (wdata),
      .raddr (raddr),
      .rdata (rd_data)
   );

   // region walk
   qus_pkg::region_type cur_ff, root, next_reg, par;
   qus_pkg::region_type stk_ff [3];
   logic [1:0]          depth_ff, next_depth, k;
   logic [5:0]          path_ff, next_path;
   logic [GL-1:0]       i_ff, j_ff, spm1;
   logic [GL:0]         sp;
   logic                pend_ff;
   logic [7:0]          lo_ff, hi_ff, cell_lo, cell_hi, spread;
   logic                uniform, last_leaf;
   logic [1:0]          q_new;

   assign sp        = (GL+1)'(qus_pkg::Grid) >> depth_ff;
   assign spm1      = GL'(sp - 1'b1);
   assign walk_addr = {cur_ff.cy + j_ff, cur_ff.cx + i_ff};
   assign sts.scan_last = (i_ff == spm1) && (j_ff == spm1);
   assign cell_lo   = rd_vld_ff ? rd_data[15:8] : 8'hFF;
   assign cell_hi   = rd_vld_ff ? rd_data[7:0] : 8'h00;
   assign spread    = (hi_ff >= lo_ff) ? hi_ff - lo_ff : 8'd0;
   assign uniform   = spread < thr_ff;
   assign sts.split = !uniform && (depth_ff < dlim_ff);

   always_comb begin
      root.xb = '0;
      root.xe = wl9[7:0];
      root.yb = '0;
      root.ye = hl9[7:0];
      root.cx = '0;
      root.cy = '0;
   end

   // deepest level that still has a later sibling
   always_comb begin
      last_leaf = 1'b1;
      k         = 2'd1;
      for (int l = 1; l <= GL; l++) begin
         if ((l <= int'(depth_ff)) && (path_ff[(GL-l)*2 +: 2] != qus_pkg::Q_BL)) begin
            last_leaf = 1'b0;
            k         = 2'(l);
         end
      end
   end
   assign sts.last_leaf = last_leaf;

   always_comb begin
      q_new     = 2'd0;
      next_path = path_ff;
      if (cmd.descend) begin
         par        = cur_ff;
         next_depth = depth_ff + 2'd1;
         q_new      = qus_pkg::Q_TL;
         next_path[(GL-1)*2 - 2*int'(depth_ff) +: 2] = qus_pkg::Q_TL;
      end else begin
         par        = stk_ff[k - 2'd1];
         next_depth = k;
         q_new      = path_ff[(GL-1)*2 - 2*(int'(k)-1) +: 2] + 2'd1;
         for (int l = 1; l <= GL; l++) begin
            if (l == int'(k)) next_path[(GL-l)*2 +: 2] = q_new;
            else if (l > int'(k)) next_path[(GL-l)*2 +: 2] = 2'd0;
         end
      end
      next_reg = qus_pkg::child(par, q_new, next_depth);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else begin
         pend_ff <= cmd.scan_step;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.walk_start || cmd.descend || cmd.advance) begin
         lo_ff <= 8'hFF;
         hi_ff <= 8'h00;
         i_ff  <= '0;
         j_ff  <= '0;
      end else begin
         if (pend_ff) begin
            if (cell_lo < lo_ff) lo_ff <= cell_lo;
            if (cell_hi > hi_ff) hi_ff <= cell_hi;
         end
         if (cmd.scan_step) begin
            if (i_ff == spm1) begin
               i_ff <= '0;
               j_ff <= j_ff + 1'b1;
            end else begin
               i_ff <= i_ff + 1'b1;
            end
         end
      end
      if (cmd.walk_start) begin
         cur_ff   <= root;
         depth_ff <= '0;
         path_ff  <= '0;
      end else if (cmd.descend || cmd.advance) begin
         cur_ff   <= next_reg;
         depth_ff <= next_depth;
         path_ff  <= next_path;
      end
      if (cmd.descend) stk_ff[depth_ff] <= cur_ff;
   end

   // result register
   logic        rvld_ff;
   logic [47:0] rdata_ff;
   logic        rlast_ff;

   assign sts.out_free = !rvld_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) rvld_ff <= 1'b0;
      else if (cmd.emit) rvld_ff <= 1'b1;
      else if (rsp_tready) rvld_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rdata_ff <= {7'd0, uniform, path_ff, depth_ff,
                      cur_ff.ye, cur_ff.xe, cur_ff.yb, cur_ff.xb};
         rlast_ff <= last_leaf;
      end
   end

   assign rsp_tvalid = rvld_ff;
   assign rsp_tdata  = rdata_ff;
   assign rsp_tlast  = rlast_ff;

endmodule

// File: rtl/quadtree_uniformity_split.sv
// Top level of the quadtree uniformity split block.
// Depends on qus_pkg, qus_ctrl, qus_datapath (and qus_ram below it).

// Pixels of a grayscale image come in on the req_ stream in raster order, one request per
// cycle while intake is open, and each updates the min/max of the finest 8x8 quadtree cell
// it falls in through a read-modify-write on a 64-entry cell store (back-to-back hits on one
// cell are forwarded). The request with req_tlast closes the image: intake stays closed for
// the drain state and the whole walk that follows, in preorder (TL, TR, BR, BL). Every region
// visited is scanned cell by cell through the store's single read port, then waits for the
// last read data and decides; each leaf then stays in the emit state until the output
// register is free. A walk that splits all the way down ends in 64 leaves. Each leaf is
// one response (corners, depth, path, uniform flag), with rsp_tlast on the final leaf. A
// response waits in a single output register: an inner leaf that finds it full stalls the
// walk, while after the final leaf the next image's pixels are taken at once. Configuration
// is written through csr_; the user must write it only while the block is idle, which the
// block itself does not enforce. Widths and heights saturate into 8..256 and the cell store
// is cleared per image by one-cycle reset of its valid bits.
module quadtree_uniformity_split (
   input  logic        clock,
   input  logic        reset,
   // configuration
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [8:0]  csr_wdata,
   // pixel requests
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] pixel
   input  logic        req_tlast,   // last_pixel
   // leaf responses
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [7:0] left_x, [15:8] top_y, [23:16] right_x,
                                    // [31:24] bottom_y, [33:32] leaf_depth,
                                    // [39:34] leaf_path, [40] is_uniform, rest zero
   output logic        rsp_tlast    // last_leaf
);

   qus_pkg::cmd_type    cmd;
   qus_pkg::status_type sts;

   qus_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .sts   (sts),
      .cmd   (cmd)
   );

   qus_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// File: rtl/qus_checker.sv
// Port-level checks for the quadtree split block, bound to the top level.
// Depends on quadtree_uniformity_split.
module qus_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        req_tlast,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata,
   input logic        rsp_tlast
);

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled response changed");

   // intake closes right after the last pixel
   a_close: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> !req_tready)
      else $error("intake open after last pixel");

   // only the final leaf may appear while intake is open
   a_mid_leaf: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) && !rsp_tlast |-> !req_tready)
      else $error("inner leaf during intake");

   // the root leaf has an empty path and is the last leaf
   a_root_path: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[33:32] == 2'd0) |-> (rsp_tdata[39:34] == 6'd0) && rsp_tlast)
      else $error("root leaf malformed");

endmodule

bind quadtree_uniformity_split qus_checker u_qus_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
